// ===== rtl/assert_macros.svh =====
// Assertion macros for the segmenter RTL (included by sas_merge)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SAS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SAS_ASSERT(lbl, prop, msg)

`define SAS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/sas_pkg.sv =====
// Types and constants for the speaker activity segmenter
`timescale 1ns / 1ps
`default_nettype none

package sas_pkg;

  localparam int NUM_SPEAKERS = 4;
  localparam int FRAME_BITS   = 32;
  localparam int CNT_W        = 32;
  localparam int PROB_W       = 16;
  localparam int SPK_W        = 2;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] FRAME_MAX = (FRAME_BITS >= CNT_W) ? {CNT_W{1'b1}} :
                                           CNT_W'((64'd1 << FRAME_BITS) - 64'd1);
  localparam logic [PROB_W-1:0] THRESHOLD_RST = 16'h8000;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    KIND_SEG    = 2'd0,
    KIND_SPK    = 2'd1,
    KIND_STREAM = 2'd2
  } kind_t;

  typedef struct packed {
    logic              op;
    logic [PROB_W-1:0] prob_a;
    logic [PROB_W-1:0] prob_b;
    logic [PROB_W-1:0] prob_c;
    logic [PROB_W-1:0] prob_d;
  } in_beat_t;

  typedef struct packed {
    kind_t             kind;
    logic [SPK_W-1:0]  speaker;
    logic [CNT_W-1:0]  start_frame;
    logic [CNT_W-1:0]  end_frame;
    logic [CNT_W-1:0]  tally;
    logic              last;
  } out_beat_t;

  typedef struct packed {
    logic             fire;
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] total;
  } lane_rpt_t;

  typedef struct packed {
    logic                                load;
    logic                                flush;
    logic [NUM_SPEAKERS-1:0]             fire;
    logic [NUM_SPEAKERS-1:0][CNT_W-1:0]  start;
    logic [NUM_SPEAKERS-1:0][CNT_W-1:0]  total;
    logic [CNT_W-1:0]                    frame_idx;
    logic [CNT_W-1:0]                    seg_total;
  } snap_load_t;

endpackage

`default_nettype wire

// ===== rtl/sas_lane.sv =====
// One speaker lane: threshold compare, segment tracking, active-frame total
`timescale 1ns / 1ps
`default_nettype none

module sas_lane
  import sas_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [PROB_W-1:0] thr,
  input  wire logic [PROB_W-1:0] prob,
  input  wire logic              frame_go,
  input  wire logic              flush_go,
  input  wire logic [CNT_W-1:0]  frame_idx,
  output lane_rpt_t              rpt
);

  logic             active_r, active_nxt;
  logic [CNT_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic             hit;

  assign hit = prob > thr;

  always_comb begin
    active_nxt = active_r;
    start_nxt  = start_r;
    total_nxt  = total_r;
    rpt.fire   = 1'b0;
    rpt.start  = start_r;
    rpt.total  = total_r;
    if (flush_go) begin
      rpt.fire   = active_r;
      active_nxt = 1'b0;
      start_nxt  = '0;
      total_nxt  = '0;
    end else if (frame_go) begin
      if (hit) begin
        total_nxt = (total_r == CNT_MAX) ? total_r : total_r + 1'b1;
        if (!active_r) begin
          active_nxt = 1'b1;
          start_nxt  = frame_idx;
        end
      end else if (active_r) begin
        active_nxt = 1'b0;
        rpt.fire   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      start_r  <= '0;
      total_r  <= '0;
    end else begin
      active_r <= active_nxt;
      start_r  <= start_nxt;
      total_r  <= total_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sas_merge.sv =====
// Result snapshot and merge: picks lane results in order, one beat per cycle while the output is not stalled
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sas_merge
  import sas_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire snap_load_t ld,
  output logic            busy,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_beat_t       out_beat
);

  localparam int PEND_W = 2 * NUM_SPEAKERS + 1;

  logic [NUM_SPEAKERS-1:0]            seg_pend_r, tot_pend_r;
  logic                               str_pend_r;
  logic [NUM_SPEAKERS-1:0][CNT_W-1:0] start_r, total_r;
  logic [CNT_W-1:0]                   end_r, segs_r;

  logic [PEND_W-1:0]       pend_vec;
  logic                    any_pend, adv, last;
  logic [NUM_SPEAKERS-1:0] seg_clr, tot_clr;
  logic                    str_clr;
  out_beat_t               pick;
  logic                    out_valid_r;
  out_beat_t               out_beat_r;
  logic                    stream_out, seg_out;

  assign pend_vec = {str_pend_r, tot_pend_r, seg_pend_r};
  assign any_pend = |pend_vec;
  assign last     = ((pend_vec & (pend_vec - 1'b1)) == '0);
  assign adv      = any_pend && (!out_valid_r || !out_stall);
  assign busy     = any_pend;

  // lowest slot first; segments before speaker totals before stream totals
  always_comb begin
    seg_clr          = '0;
    tot_clr          = '0;
    str_clr          = 1'b1;
    pick.kind        = KIND_STREAM;
    pick.speaker     = '0;
    pick.start_frame = '0;
    pick.end_frame   = end_r;
    pick.tally       = segs_r;
    pick.last        = last;
    for (int i = NUM_SPEAKERS - 1; i >= 0; i--) begin
      if (tot_pend_r[i]) begin
        str_clr          = 1'b0;
        tot_clr          = '0;
        tot_clr[i]       = 1'b1;
        pick.kind        = KIND_SPK;
        pick.speaker     = SPK_W'(i);
        pick.start_frame = '0;
        pick.end_frame   = '0;
        pick.tally       = total_r[i];
      end
    end
    for (int i = NUM_SPEAKERS - 1; i >= 0; i--) begin
      if (seg_pend_r[i]) begin
        str_clr          = 1'b0;
        tot_clr          = '0;
        seg_clr          = '0;
        seg_clr[i]       = 1'b1;
        pick.kind        = KIND_SEG;
        pick.speaker     = SPK_W'(i);
        pick.start_frame = start_r[i];
        pick.end_frame   = end_r;
        pick.tally       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_pend_r <= '0;
      tot_pend_r <= '0;
      str_pend_r <= 1'b0;
    end else if (ld.load) begin
      seg_pend_r <= ld.fire;
      tot_pend_r <= {NUM_SPEAKERS{ld.flush}};
      str_pend_r <= ld.flush;
    end else if (adv) begin
      seg_pend_r <= seg_pend_r & ~seg_clr;
      tot_pend_r <= tot_pend_r & ~tot_clr;
      str_pend_r <= str_pend_r & ~str_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      start_r <= ld.start;
      total_r <= ld.total;
      end_r   <= ld.frame_idx;
      segs_r  <= ld.seg_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= any_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_beat_r <= pick;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  assign stream_out = out_valid_r && (out_beat_r.kind == KIND_STREAM);
  assign seg_out    = out_valid_r && (out_beat_r.kind == KIND_SEG);

  `SAS_ASSERT(a_load_idle, ld.load |-> !any_pend, "snapshot loaded while results pending")
  `SAS_ASSERT(a_drain_one, adv |=> $onehot($past(pend_vec) & ~pend_vec), "bad drain step")
  `SAS_ASSERT(a_stream_last, stream_out |-> out_beat_r.last, "stream beat without last")
  `SAS_ASSERT(a_seg_tally, seg_out |-> out_beat_r.tally == '0, "segment beat with nonzero tally")

endmodule

`default_nettype wire

// ===== rtl/speaker_activity_segmenter_core.sv =====
// Speaker activity segmenter: four threshold lanes, stream counters, result merge
// Results are captured into pending registers when the input beat is accepted, then leave through the output register.
// Input stall: input is held while results of the last accepted beat are pending (closed
// segments; on a flush also speaker and stream totals); a frame closing none is not held.
// The next input is taken while the final result still waits in the output register.
// Reset (rst_n low, synchronous) clears all lane state and counters; threshold = 0x8000.
`timescale 1ns / 1ps
`default_nettype none

module speaker_activity_segmenter_core
  import sas_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [PROB_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_beat_t          in_beat,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_beat_t              out_beat
);

  logic [PROB_W-1:0] thr_r;
  logic [CNT_W-1:0]  frame_cnt_r, frame_cnt_nxt;
  logic [CNT_W-1:0]  seg_cnt_r, seg_cnt_nxt;
  logic              busy, accept, frame_go, flush_go;
  logic [2:0]        n_fire;
  logic [CNT_W:0]    seg_sum;
  logic [CNT_W-1:0]  seg_sat;

  logic [3:0][PROB_W-1:0]      probs;
  lane_rpt_t [NUM_SPEAKERS-1:0] rpt;
  snap_load_t                   ld;

  assign accept   = in_valid && !busy;
  assign frame_go = accept && (in_beat.op == OP_FRAME);
  assign flush_go = accept && (in_beat.op == OP_FLUSH);
  assign in_stall = busy;
  assign probs    = {in_beat.prob_d, in_beat.prob_c, in_beat.prob_b, in_beat.prob_a};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RST;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  for (genvar g = 0; g < NUM_SPEAKERS; g++) begin : g_lane
    sas_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .thr       (thr_r),
      .prob      (probs[g]),
      .frame_go  (frame_go),
      .flush_go  (flush_go),
      .frame_idx (frame_cnt_r),
      .rpt       (rpt[g])
    );
  end

  always_comb begin
    n_fire = '0;
    for (int i = 0; i < NUM_SPEAKERS; i++) begin
      n_fire = n_fire + 3'(rpt[i].fire);
    end
  end

  assign seg_sum = {1'b0, seg_cnt_r} + (CNT_W+1)'(n_fire);
  assign seg_sat = seg_sum[CNT_W] ? CNT_MAX : seg_sum[CNT_W-1:0];

  always_comb begin
    frame_cnt_nxt = frame_cnt_r;
    seg_cnt_nxt   = seg_cnt_r;
    if (flush_go) begin
      frame_cnt_nxt = '0;
      seg_cnt_nxt   = '0;
    end else if (frame_go) begin
      frame_cnt_nxt = (frame_cnt_r >= FRAME_MAX) ? FRAME_MAX : frame_cnt_r + 1'b1;
      seg_cnt_nxt   = seg_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= '0;
      seg_cnt_r   <= '0;
    end else begin
      frame_cnt_r <= frame_cnt_nxt;
      seg_cnt_r   <= seg_cnt_nxt;
    end
  end

  always_comb begin
    ld.load      = accept;
    ld.flush     = flush_go;
    ld.frame_idx = frame_cnt_r;
    ld.seg_total = seg_sat;
    for (int i = 0; i < NUM_SPEAKERS; i++) begin
      ld.fire[i]  = rpt[i].fire;
      ld.start[i] = rpt[i].start;
      ld.total[i] = rpt[i].total;
    end
  end

  sas_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the speaker activity segmenter: directed and random streams, local predictor
`timescale 1ns / 1ps

module tb_top
  import sas_pkg::*;
();

  localparam int GAP_MAX    = 15;
  localparam int DRAIN_CYC  = 16;
  localparam int HANG_LIMIT = 2000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [PROB_W-1:0] cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_beat_t          in_beat   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_beat_t         out_beat;

  speaker_activity_segmenter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [PROB_W-1:0]       cur_thr;
  logic [NUM_SPEAKERS-1:0] talking;
  logic [CNT_W-1:0]        seg_open_at [NUM_SPEAKERS];
  logic [CNT_W-1:0]        talk_frames [NUM_SPEAKERS];
  logic [CNT_W-1:0]        frame_no;
  logic [CNT_W-1:0]        seg_tally;
  out_beat_t               held;
  bit                      held_ok;

  out_beat_t report_q [$];
  in_beat_t  frame_q [$];
  out_beat_t want;

  int errors     = 0;
  int beats_in   = 0;
  int flushes_in = 0;
  int beats_out  = 0;
  int segs_out   = 0;
  int settings   = 0;
  int in_gap     = 0;
  int out_gap    = 0;
  int quiet      = 0;
  bit in_tight   = 1'b0;
  bit out_tight  = 1'b0;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v,
                                            input logic [CNT_W-1:0] top);
    return (v >= top) ? top : v + 1'b1;
  endfunction

  function automatic int draw_gap(input bit tight);
    return tight ? 0 : int'($urandom_range(GAP_MAX, 0));
  endfunction

  task automatic clear_speakers;
    talking   = '0;
    frame_no  = '0;
    seg_tally = '0;
    for (int s = 0; s < NUM_SPEAKERS; s++) begin
      seg_open_at[s] = '0;
      talk_frames[s] = '0;
    end
  endtask

  // results are held back by one so the final one can be marked last
  task automatic emit(input kind_t k, input int spk, input logic [CNT_W-1:0] st,
                      input logic [CNT_W-1:0] en, input logic [CNT_W-1:0] ta);
    if (held_ok) report_q = {report_q, held};
    held.kind        = k;
    held.speaker     = SPK_W'(spk);
    held.start_frame = st;
    held.end_frame   = en;
    held.tally       = ta;
    held.last        = 1'b0;
    held_ok          = 1'b1;
  endtask

  task automatic advance_speakers(input in_beat_t b);
    logic [PROB_W-1:0] probs [NUM_SPEAKERS];
    logic [CNT_W-1:0]  fidx;
    probs[0] = b.prob_a;
    probs[1] = b.prob_b;
    probs[2] = b.prob_c;
    probs[3] = b.prob_d;
    held_ok  = 1'b0;
    if (b.op == OP_FRAME) begin
      fidx = frame_no;
      for (int s = 0; s < NUM_SPEAKERS; s++) begin
        if (probs[s] > cur_thr) begin
          talk_frames[s] = bump(talk_frames[s], CNT_MAX);
          if (!talking[s]) begin
            talking[s]     = 1'b1;
            seg_open_at[s] = fidx;
          end
        end else if (talking[s]) begin
          talking[s] = 1'b0;
          emit(KIND_SEG, s, seg_open_at[s], fidx, '0);
          seg_tally = bump(seg_tally, CNT_MAX);
        end
      end
      frame_no = bump(frame_no, FRAME_MAX);
    end else begin
      for (int s = 0; s < NUM_SPEAKERS; s++) begin
        if (talking[s]) begin
          emit(KIND_SEG, s, seg_open_at[s], frame_no, '0);
          seg_tally = bump(seg_tally, CNT_MAX);
        end
      end
      for (int s = 0; s < NUM_SPEAKERS; s++) emit(KIND_SPK, s, '0, '0, talk_frames[s]);
      emit(KIND_STREAM, 0, '0, frame_no, seg_tally);
      clear_speakers();
    end
    if (held_ok) begin
      held.last = 1'b1;
      report_q  = {report_q, held};
    end
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] want_v,
                             input logic [CNT_W-1:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_speakers(in_beat);
        beats_in++;
        if (in_beat.op == OP_FLUSH) flushes_in++;
        in_gap = draw_gap(in_tight);
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (frame_q.size() > 0) begin
          in_beat  <= frame_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out++;
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat: expected none, actual %h", $time, out_beat);
        end else begin
          want = report_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_beat.kind));
          check_field("speaker", 32'(want.speaker), 32'(out_beat.speaker));
          check_field("start_frame", want.start_frame, out_beat.start_frame);
          check_field("end_frame", want.end_frame, out_beat.end_frame);
          check_field("tally", want.tally, out_beat.tally);
          check_field("last", 32'(want.last), 32'(out_beat.last));
          if (want.kind == KIND_SEG) segs_out++;
        end
        out_gap = draw_gap(out_tight);
      end
      out_stall <= (out_gap > 0);
      if (out_gap > 0) out_gap--;
    end
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= HANG_LIMIT) begin
      $display("%0t watchdog expired, %0d results outstanding", $time, report_q.size());
      $display("FAIL speaker_activity_segmenter_core");
      $finish;
    end
  end

  task automatic put_beat(input logic op, input logic [PROB_W-1:0] a, input logic [PROB_W-1:0] b,
                          input logic [PROB_W-1:0] c, input logic [PROB_W-1:0] d);
    in_beat_t bt;
    bt.op     = op;
    bt.prob_a = a;
    bt.prob_b = b;
    bt.prob_c = c;
    bt.prob_d = d;
    frame_q   = {frame_q, bt};
  endtask

  // probability above or below the threshold, sometimes right at the edge
  function automatic logic [PROB_W-1:0] level(input bit on, input logic [PROB_W-1:0] t);
    int lo, hi;
    bit up;
    up = on && (t != '1);
    if (up) begin
      lo = int'(t) + 1;
      hi = 65535;
    end else begin
      lo = 0;
      hi = int'(t);
    end
    if ($urandom_range(3, 0) == 0) return PROB_W'(up ? lo : hi);
    return PROB_W'($urandom_range(hi, lo));
  endfunction

  task automatic queue_stream(input int len, input bit close);
    logic [NUM_SPEAKERS-1:0] talk;
    logic [PROB_W-1:0]       p [NUM_SPEAKERS];
    talk = NUM_SPEAKERS'($urandom);
    for (int i = 0; i < len; i++) begin
      for (int s = 0; s < NUM_SPEAKERS; s++) begin
        if ($urandom_range(3, 0) == 0) talk[s] = ~talk[s];
        p[s] = level(talk[s], cur_thr);
      end
      put_beat(OP_FRAME, p[0], p[1], p[2], p[3]);
    end
    if (close)
      put_beat(OP_FLUSH, PROB_W'($urandom), PROB_W'($urandom), PROB_W'($urandom),
               PROB_W'($urandom));
  endtask

  task automatic queue_noise(input int n);
    for (int i = 0; i < n; i++)
      put_beat(($urandom_range(3, 0) == 0) ? OP_FLUSH : OP_FRAME, PROB_W'($urandom),
               PROB_W'($urandom), PROB_W'($urandom), PROB_W'($urandom));
  endtask

  task automatic settle;
    @(negedge clk);
    while (frame_q.size() != 0 || in_valid || report_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [PROB_W-1:0] t);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_thr = t;
    settings++;
    @(negedge clk);
  endtask

  initial begin
    logic [PROB_W-1:0] thr_plan [9];
    int budget, len;
    cur_thr = THRESHOLD_RST;
    clear_speakers();
    thr_plan[0] = 16'h0000;
    thr_plan[1] = 16'hFFFF;
    thr_plan[2] = 16'h0001;
    thr_plan[3] = 16'hFFFE;
    thr_plan[4] = PROB_W'($urandom);
    thr_plan[5] = PROB_W'($urandom);
    thr_plan[6] = PROB_W'($urandom);
    thr_plan[7] = PROB_W'($urandom);
    thr_plan[8] = 16'h8000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    settings = 1;

    // directed, reset threshold
    @(negedge clk);
    put_beat(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    put_beat(OP_FRAME, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    put_beat(OP_FRAME, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    put_beat(OP_FRAME, 16'h8001, 16'h8001, 16'h8001, 16'h8001);
    put_beat(OP_FRAME, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    put_beat(OP_FRAME, 16'hFFFF, 16'h0000, 16'h8001, 16'h8000);
    put_beat(OP_FRAME, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    put_beat(OP_FRAME, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    put_beat(OP_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    put_beat(OP_FRAME, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    put_beat(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    put_beat(OP_FRAME, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    put_beat(OP_FRAME, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    put_beat(OP_FRAME, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8001);
    put_beat(OP_FRAME, 16'h8001, 16'h8000, 16'h7FFF, 16'h0000);
    put_beat(OP_FLUSH, 16'h1234, 16'hFEDC, 16'h5A5A, 16'hA5A5);
    settle();

    foreach (thr_plan[i]) begin
      set_threshold(thr_plan[i]);
      in_tight  = ($urandom_range(3, 0) == 0);
      out_tight = ($urandom_range(3, 0) == 0);
      budget = 20;
      while (budget > 0) begin
        len = (($urandom_range(7, 0) == 0) ? 0 : int'($urandom_range(12, 1)));
        queue_stream(len, $urandom_range(5, 0) != 0);
        budget -= len + 1;
      end
      queue_noise(3);
      settle();
    end

    $display("Covered %0d input beats including %0d flushes, %0d result beats with %0d segments",
             beats_in, flushes_in, beats_out, segs_out);
    $display("across %0d threshold settings, %0d field mismatches or stray results",
             settings, errors);
    if (errors == 0) begin
      $display("PASS speaker_activity_segmenter_core");
    end else begin
      $display("FAIL speaker_activity_segmenter_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sas_pkg.sv
rtl/sas_lane.sv
rtl/sas_merge.sv
rtl/speaker_activity_segmenter_core.sv
dv/tb_top.sv
